[rtl/core/ifdl_pkg.sv]
`default_nettype none
// ============================================================================
// ifdl_pkg
// Shared types and fixed constants of the interpolated feedback delay line.
// ============================================================================
package ifdl_pkg;

  // Fixed field widths of the ports
  localparam int DELAY_BITS = 24;   // requested delay, unsigned Q16.8
  localparam int MAX_BITS   = 16;   // maximum delay register
  localparam int GAIN_BITS  = 17;   // feedback gain, unsigned Q1.16

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 17'd65536;
  localparam int MAX_RESET = 1024;
  localparam int FB_SHIFT  = 16;

  // Four neighbouring samples feed the interpolator, three Horner steps
  localparam int TAP_COUNT     = 4;
  localparam int HERMITE_STEPS = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_ADDR,
    ST_PREP,
    ST_READ,
    ST_START,
    ST_INTERP,
    ST_FBMUL,
    ST_FBWR,
    ST_DONE
  } fsm_state_t;

endpackage
`default_nettype wire

[rtl/core/ifdl_store.sv]
`default_nettype none
// ============================================================================
// ifdl_store
// Single-port sample memory with a registered read port.
// ============================================================================
module ifdl_store #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data <= mem[addr];
  end

endmodule
`default_nettype wire

[rtl/core/ifdl_interp.sv]
`default_nettype none
// ============================================================================
// ifdl_interp
// Four-point cubic Hermite interpolator, evaluated by Horner steps over a
// shared multiplier, one step per cycle.
// ============================================================================
module ifdl_interp #(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] xm1,
  input  logic signed [SAMPLE_BITS-1:0] x0,
  input  logic signed [SAMPLE_BITS-1:0] x1,
  input  logic signed [SAMPLE_BITS-1:0] x2,
  input  logic        [FRAC_BITS-1:0]   frac,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] y
);
  import ifdl_pkg::*;

  localparam int TW = SAMPLE_BITS + 6;
  localparam int PW = TW + FRAC_BITS + 1;
  localparam int STEP_BITS = $clog2(HERMITE_STEPS + 1);

  logic signed [TW-1:0] em1, e0, e1, e2;
  logic signed [TW-1:0] coef_a, coef_b, coef_c, coef_d, diff_01;
  logic signed [TW-1:0] t, cb, cc, cd, addend, t_next, rnd;
  logic signed [PW-1:0] prod, prod_sh;
  logic [FRAC_BITS-1:0] fr;
  logic [STEP_BITS-1:0] step;
  logic                 busy;
  logic signed [SAMPLE_BITS-1:0] rnd_sat;

  // Doubled Catmull-Rom coefficients
  always_comb begin
    em1     = TW'(xm1);
    e0      = TW'(x0);
    e1      = TW'(x1);
    e2      = TW'(x2);
    diff_01 = e0 - e1;
    coef_a  = (e2 - em1) + (diff_01 <<< 1) + diff_01;
    coef_b  = (em1 <<< 1) - ((e0 <<< 2) + e0) + (e1 <<< 2) - e2;
    coef_c  = e1 - em1;
    coef_d  = e0 <<< 1;
  end

  always_comb begin
    case (step)
      STEP_BITS'(0): addend = cb;
      STEP_BITS'(1): addend = cc;
      default:       addend = cd;
    endcase
    prod    = PW'(t) * PW'($signed({1'b0, fr}));
    prod_sh = prod >>> FRAC_BITS;
    t_next  = TW'(prod_sh) + addend;
  end

  // Round half up, then clamp to the sample range
  always_comb begin
    rnd = (t + TW'(1)) >>> 1;
    if (rnd[TW-1:SAMPLE_BITS-1] != '0 && rnd[TW-1:SAMPLE_BITS-1] != '1) begin
      rnd_sat = rnd[TW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                          : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      rnd_sat = rnd[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_BITS'(HERMITE_STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + STEP_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t  <= coef_a;
      cb <= coef_b;
      cc <= coef_c;
      cd <= coef_d;
      fr <= frac;
    end else if (busy) begin
      if (step == STEP_BITS'(HERMITE_STEPS)) begin
        y <= rnd_sat;
      end else begin
        t <= t_next;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/interpolated_feedback_delay_line_top.sv]
`default_nettype none
// ============================================================================
// interpolated_feedback_delay_line_top
// Single-channel fractional delay line with cubic Hermite interpolation and
// saturating feedback into the sample store.
// ============================================================================
// After reset the block sweeps the whole sample store to zero, one entry per
// cycle, so in_ready stays low until the sweep has ended; configuration
// writes are taken during that sweep as at any other time. Each
// accepted item is written into a circular store whose length is the maximum
// delay plus two. The output is interpolated at the write position minus the
// requested delay (unsigned Q16.8, clipped to the maximum), and when that
// delay is one sample or more the output scaled by the feedback gain is added
// back into the entry just written, with saturation. The block works on one
// item at a time and takes the next only once the last result has gone to
// the output register; its pace is set by the single memory port, which
// carries one write, four reads and one write back per item, and by the
// three Horner steps of the interpolator's multiplier. The
// next item may be accepted while a result is still waiting in the output
// register. Writing max_delay_samples returns the write position to the start
// of the store, and must only be done while the block is idle.
// ============================================================================
module interpolated_feedback_delay_line_top #(
  parameter int DEPTH       = 65536,
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ifdl_pkg::MAX_BITS-1:0]       max_delay_samples,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  input  logic [ifdl_pkg::DELAY_BITS-1:0]     delay_q,
  input  logic [ifdl_pkg::GAIN_BITS-1:0]      feedback_gain,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       sample_out
);
  import ifdl_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int QW = ((DELAY_BITS > LW + FRAC_BITS) ? DELAY_BITS : LW + FRAC_BITS) + 1;
  localparam int MAX_CAP  = DEPTH - 2;
  localparam int MAX_INIT = (MAX_CAP < MAX_RESET) ? MAX_CAP : MAX_RESET;
  localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int SW = SAMPLE_BITS + 2;
  localparam int CW = $clog2(TAP_COUNT + 1);

  // Advance a store position by one, wrapping at the buffer length in use.
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] pos,
                                             input logic [LW-1:0] len);
    logic [LW:0] sum;
    sum = (LW+1)'(pos) + (LW+1)'(1);
    if (sum == (LW+1)'(len)) begin
      return '0;
    end
    return AW'(sum);
  endfunction

  fsm_state_t state, state_next;

  // Configuration: effective maximum and buffer length
  logic [MAX_BITS-1:0] max_eff, cfg_max_clip;
  logic [LW-1:0]       buf_len, cfg_len;
  logic [AW-1:0]       wp;

  // Latched item and derived addressing
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic [DELAY_BITS-1:0]         dq;
  logic [GAIN_BITS-1:0]          gain;
  logic [QW-1:0]                 dclip, dmax, wpq, lenq, rpos;
  logic [AW-1:0]                 idx, rd_addr;
  logic [FRAC_BITS-1:0]          frac;
  logic [CW-1:0]                 rd_cnt;
  logic                          rd_pend;
  logic signed [SAMPLE_BITS-1:0] taps [TAP_COUNT];

  // Memory port
  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [SAMPLE_BITS-1:0] mem_wdata, rd_data;

  // Clearing sweep
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  // Interpolator and feedback path
  logic                          interp_start, interp_done, rd_issue;
  logic signed [SAMPLE_BITS-1:0] y;
  logic signed [PW-1:0]          fb_prod, fb_round;
  logic signed [SW-1:0]          fb_sum;
  logic signed [SAMPLE_BITS-1:0] fb_sat, fb_wdata;
  logic                          fb_on, out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE) && !clr_active;
  assign out_free  = !out_valid || out_ready;

  // A zero maximum behaves as one sample; anything beyond the store is capped.
  always_comb begin
    cfg_max_clip = max_delay_samples;
    if (max_delay_samples == '0) begin
      cfg_max_clip = MAX_BITS'(1);
    end
    if (32'(max_delay_samples) > MAX_CAP) begin
      cfg_max_clip = MAX_BITS'(MAX_CAP);
    end
    cfg_len = LW'(32'(cfg_max_clip) + 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_eff <= MAX_BITS'(MAX_INIT);
      buf_len <= LW'(MAX_INIT + 2);
      wp      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_eff <= cfg_max_clip;
        buf_len <= cfg_len;
        wp      <= '0;
      end else if (state == ST_FBWR) begin
        wp <= wrap_inc(wp, buf_len);
      end
    end
  end

  // The store is zeroed once after reset before any item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_cnt  <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_issue;
      if (state == ST_READ) begin
        rd_cnt <= rd_cnt + CW'(1);
      end else begin
        rd_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid && in_ready) state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_ADDR;
      ST_ADDR:   state_next = ST_PREP;
      ST_PREP:   state_next = ST_READ;
      ST_READ:   if (rd_cnt == CW'(TAP_COUNT)) state_next = ST_START;
      ST_START:  state_next = ST_INTERP;
      ST_INTERP: if (interp_done) state_next = ST_FBMUL;
      ST_FBMUL:  state_next = ST_FBWR;
      ST_FBWR:   state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory port use per state; the sweep owns the port while it runs.
  always_comb begin
    mem_we       = 1'b0;
    mem_addr     = rd_addr;
    mem_wdata    = x_in;
    rd_issue     = 1'b0;
    interp_start = 1'b0;
    unique case (state)
      ST_WRITE: begin
        mem_we   = 1'b1;
        mem_addr = wp;
      end
      ST_READ: begin
        rd_issue = (rd_cnt < CW'(TAP_COUNT));
      end
      ST_START: begin
        interp_start = 1'b1;
      end
      ST_FBWR: begin
        mem_we    = 1'b1;
        mem_addr  = wp;
        mem_wdata = fb_wdata;
      end
      ST_IDLE, ST_ADDR, ST_PREP, ST_INTERP, ST_FBMUL, ST_DONE: begin
      end
      default: begin
      end
    endcase
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_addr  = clr_addr;
      mem_wdata = '0;
    end
  end

  // Read position: the write position less the clipped delay, wrapped into
  // the buffer length in use.
  always_comb begin
    dmax = QW'(max_eff) << FRAC_BITS;
    wpq  = QW'(wp) << FRAC_BITS;
    lenq = QW'(buf_len) << FRAC_BITS;
    if (wpq >= dclip) begin
      rpos = wpq - dclip;
    end else begin
      rpos = wpq + lenq - dclip;
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_in <= sample_in;
      dq   <= delay_q;
      gain <= (feedback_gain > GAIN_ONE) ? GAIN_ONE : feedback_gain;
    end
    if (state == ST_WRITE) begin
      dclip <= (QW'(dq) > dmax) ? dmax : QW'(dq);
    end
    if (state == ST_ADDR) begin
      idx  <= AW'(rpos >> FRAC_BITS);
      frac <= rpos[FRAC_BITS-1:0];
    end
    // The four reads walk from the sample before the read point onwards.
    if (state == ST_PREP) begin
      rd_addr <= (idx == '0) ? AW'(buf_len - LW'(1)) : idx - AW'(1);
    end else if (rd_issue) begin
      rd_addr <= wrap_inc(rd_addr, buf_len);
    end
    if (rd_pend) begin
      for (int k = 0; k < TAP_COUNT - 1; k++) begin
        taps[k] <= taps[k+1];
      end
      taps[TAP_COUNT-1] <= rd_data;
    end
    if (state == ST_FBMUL) begin
      fb_prod <= PW'(y) * PW'($signed({1'b0, gain}));
    end
  end

  // Feedback: round the scaled output, add it to the new sample, saturate.
  always_comb begin
    fb_on    = (dclip[QW-1:FRAC_BITS] != '0);
    fb_round = (fb_prod + PW'(1 << (FB_SHIFT - 1))) >>> FB_SHIFT;
    fb_sum   = SW'(x_in) + SW'(fb_round);
    if (fb_sum[SW-1:SAMPLE_BITS-1] != '0 && fb_sum[SW-1:SAMPLE_BITS-1] != '1) begin
      fb_sat = fb_sum[SW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                            : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      fb_sat = fb_sum[SAMPLE_BITS-1:0];
    end
    fb_wdata = fb_on ? fb_sat : x_in;
  end

  // Output register parts the result from the next item's work.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      sample_out <= y;
    end
  end

  ifdl_store #(
    .DEPTH (DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rd_data (rd_data)
  );

  ifdl_interp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_interp (
    .clk   (clk),
    .rst   (rst),
    .start (interp_start),
    .xm1   (taps[0]),
    .x0    (taps[1]),
    .x1    (taps[2]),
    .x2    (taps[3]),
    .frac  (frac),
    .done  (interp_done),
    .y     (y)
  );

endmodule
`default_nettype wire

[tb/tb_interpolated_feedback_delay_line_top.sv]
`default_nettype none
// ============================================================================
// tb_interpolated_feedback_delay_line_top
// Self-checking bench for the interpolated feedback delay line. A tracker
// class keeps its own copy of the sample store and write position. It works
// out every delayed, Hermite-interpolated sample and its feedback write-back,
// and checks each result item against the oldest expected sample. Directed
// items cover the extremes and the saturation cases. Random items then run
// under a sweep of maximum-delay settings, with random idling on both sides.
// ============================================================================
module tb_interpolated_feedback_delay_line_top;
  import ifdl_pkg::*;

  localparam int DEPTH       = 65536;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 8;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h800000;

  // Random items per maximum-delay setting, and the number of settings.
  localparam int ITEMS_PER_SETTING = 128;
  localparam int SETTING_COUNT     = 10;
  // The long hold on the result side, in cycles.
  localparam int LONG_HOLD   = 300;
  // Cycles allowed after the last expected result, to catch stray items.
  localparam int TAIL_CYCLES = 40;
  // The store sweep after reset is the longest silence of the block. Nothing
  // else in a correct run comes near it, so a limit built from the store depth
  // and the long hold, with margin, is safe for cycles without any handshake.
  localparam int QUIET_LIMIT = 4 * DEPTH + 4 * LONG_HOLD;

  // --------------------------------------------------------------------------
  // Tracker: predicts the delayed samples and checks the result items.
  // --------------------------------------------------------------------------
  class delay_line_tracker;
    logic signed [SAMPLE_BITS-1:0] store [DEPTH];
    longint unsigned               write_pos;
    logic [MAX_BITS-1:0]           max_reg;
    logic [SAMPLE_BITS-1:0]        expected_samples [$];
    int                            mismatches;
    int                            checked;
    int                            clipped;

    function new();
      foreach (store[k]) store[k] = '0;
      write_pos  = 0;
      max_reg    = MAX_BITS'(MAX_RESET);
      mismatches = 0;
      checked    = 0;
      clipped    = 0;
    endfunction

    function void set_max(logic [MAX_BITS-1:0] value);
      max_reg   = value;
      write_pos = 0;
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    function logic signed [SAMPLE_BITS-1:0] clip(longint v);
      if (v > longint'(2 ** (SAMPLE_BITS - 1) - 1)) return SAMPLE_MAX;
      if (v < -longint'(2 ** (SAMPLE_BITS - 1))) return SAMPLE_MIN;
      return v[SAMPLE_BITS-1:0];
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    // Writes the sample, reads the four taps around the delayed position,
    // applies the feedback and queues the interpolated result.
    function void note_input(logic signed [SAMPLE_BITS-1:0] s,
                             logic [DELAY_BITS-1:0] dq,
                             logic [GAIN_BITS-1:0] g);
      longint unsigned lim, span, wp, dmax, d, pos;
      longint unsigned tap;
      longint frac, gain, xm1, x0, x1, x2, acc, y;
      logic signed [SAMPLE_BITS-1:0] sat;
      // A maximum of zero acts as one; above the store size less two it is held there.
      lim  = (max_reg == 0) ? 1 : ((max_reg > DEPTH - 2) ? DEPTH - 2 : max_reg);
      span = lim + 2;
      wp   = (write_pos >= span) ? 0 : write_pos;
      gain = (g > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g);
      dmax = lim << FRAC_BITS;
      d    = (dq > dmax) ? dmax : dq;

      store[wp] = s;

      pos  = wp << FRAC_BITS;
      pos  = (pos >= d) ? pos - d : pos + (span << FRAC_BITS) - d;
      tap  = (pos >> FRAC_BITS) % span;
      frac = longint'(pos & ((1 << FRAC_BITS) - 1));
      xm1  = store[(tap + span - 1) % span];
      x0   = store[tap];
      x1   = store[(tap + 1) % span];
      x2   = store[(tap + 2) % span];

      // Horner form of the doubled Catmull-Rom polynomial, flooring each step.
      acc = (x2 - xm1) + 3 * (x0 - x1);
      acc = ((acc * frac) >>> FRAC_BITS) + 2 * xm1 - 5 * x0 + 4 * x1 - x2;
      acc = ((acc * frac) >>> FRAC_BITS) + (x1 - xm1);
      acc = ((acc * frac) >>> FRAC_BITS) + 2 * x0;
      y   = (acc + 1) >>> 1;
      sat = clip(y);
      if (longint'(sat) != y) clipped++;

      // Feedback only when the delay is a whole sample or more.
      if (d >= (1 << FRAC_BITS))
        store[wp] = clip(longint'(s) + ((longint'(sat) * gain + 32768) >>> FB_SHIFT));

      write_pos = (wp + 1 >= span) ? 0 : wp + 1;
      expected_samples.push_back(sat);
    endfunction

    task check_output(logic [SAMPLE_BITS-1:0] got);
      logic [SAMPLE_BITS-1:0] want;
      if (expected_samples.size() == 0) begin
        report($sformatf("sample_out %0d arrived with no item pending",
                         $signed(got)));
      end else begin
        want = expected_samples.pop_front();
        checked++;
        if (got !== want)
          report($sformatf("result %0d: sample_out %0d, expected %0d",
                           checked, $signed(got), $signed(want)));
      end
    endtask

    task close_out();
      if (expected_samples.size() != 0)
        report($sformatf("%0d expected samples never arrived",
                         expected_samples.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its signals. Every input has a known value from the
  // first instant of the run.
  // --------------------------------------------------------------------------
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [MAX_BITS-1:0]           max_delay_samples = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_in = '0;
  logic [DELAY_BITS-1:0]         delay_q = '0;
  logic [GAIN_BITS-1:0]          feedback_gain = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  interpolated_feedback_delay_line_top #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .max_delay_samples (max_delay_samples),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .sample_in         (sample_in),
    .delay_q           (delay_q),
    .feedback_gain     (feedback_gain),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .sample_out        (sample_out)
  );

  delay_line_tracker tracker = new();

  // Shared controls between the stimulus and the result side. While calm is
  // set neither side idles; sink_hold asks the result side for one long hold.
  bit calm      = 1'b0;
  bit sink_hold = 1'b0;
  int items_sent   = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  int unsigned max_sweep [SETTING_COUNT] =
    '{0, 1, 2, 7, 33, 1024, 65535, 65534, 300, 5};

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side. Inputs change on the falling edge. The ready line idles at
  // random unless calm is set. A long hold lets the block fill up, so that
  // its input stalls while items keep being offered.
  // --------------------------------------------------------------------------
  initial begin : result_side
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        sink_hold = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // Results are sampled on the rising edge at which the handshake completes.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.check_output(sample_out);
      results_seen++;
    end
  end

  // The watchdog counts cycles in which no handshake of any kind takes place.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("tb_interpolated_feedback_delay_line_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers.
  // --------------------------------------------------------------------------

  // Offers one item, idling first at random, and returns at the rising edge
  // at which it is taken. Valid is left high so that back-to-back items need
  // no drop in between; whoever stops sending lowers it.
  task automatic send_item(input logic [SAMPLE_BITS-1:0] s,
                           input logic [DELAY_BITS-1:0] dq,
                           input logic [GAIN_BITS-1:0] g);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    sample_in     <= s;
    delay_q       <= dq;
    feedback_gain <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_input(s, dq, g);
    items_sent++;
  endtask

  // Stops offering and waits until every expected sample has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Writes the maximum delay register. It is only called with the block idle.
  task automatic write_max(input int unsigned value);
    @(negedge clk);
    cfg_valid         <= 1'b1;
    max_delay_samples <= MAX_BITS'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_max(MAX_BITS'(value));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random item for an effective maximum of lim samples. Delays mostly
  // fall within reach of the maximum, with whole-sample values, values close
  // to the clip point and the occasional full-range value mixed in.
  task automatic send_random(input int unsigned lim);
    logic [SAMPLE_BITS-1:0] s;
    logic [DELAY_BITS-1:0]  dq;
    logic [GAIN_BITS-1:0]   g;
    case ($urandom_range(0, 9))
      0:       s = SAMPLE_MAX;
      1:       s = SAMPLE_MIN;
      2:       s = SAMPLE_BITS'($urandom_range(0, 510)) - SAMPLE_BITS'(255);
      default: s = SAMPLE_BITS'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       dq = DELAY_BITS'($urandom);
      1:       dq = '0;
      2:       dq = DELAY_BITS'($urandom_range(0, lim) << FRAC_BITS);
      3:       dq = DELAY_BITS'((lim << FRAC_BITS) + $urandom_range(0, 511) - 256);
      default: dq = DELAY_BITS'($urandom_range(0, (lim << FRAC_BITS) + 255));
    endcase
    case ($urandom_range(0, 7))
      0:       g = GAIN_BITS'($urandom_range(65537, 131071));
      1:       g = GAIN_ONE;
      2:       g = '0;
      default: g = GAIN_BITS'($urandom_range(0, 65536));
    endcase
    send_item(s, dq, g);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned lim;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed items under the reset maximum of 1024. The first four store
    // a low, high, high, low run and then read it half-way between the two
    // high samples. The interpolation overshoots there and must saturate
    // upwards; the next four mirror that downwards.
    send_item(SAMPLE_MIN, 24'd0,   17'd0);
    send_item(SAMPLE_MAX, 24'd0,   GAIN_ONE);
    send_item(SAMPLE_MAX, 24'd0,   17'd131071);
    send_item(SAMPLE_MIN, 24'd384, 17'd0);
    send_item(SAMPLE_MAX, 24'd0,   17'd0);
    send_item(SAMPLE_MIN, 24'd0,   17'd0);
    send_item(SAMPLE_MIN, 24'd0,   17'd0);
    send_item(SAMPLE_MAX, 24'd384, 17'd0);
    // One sample of delay at full gain, so the write-back saturates, then a
    // gain just above one, which must be held at one.
    send_item(SAMPLE_MAX, 24'd256, GAIN_ONE);
    send_item(SAMPLE_MIN, 24'd256, 17'd65537);
    // Just short of one sample: no feedback, largest fraction.
    send_item(24'd1, 24'd255, GAIN_ONE);
    // Largest delay field, clipped to the maximum; then exactly the maximum
    // and just above it.
    send_item(24'hFFFFFF, 24'hFFFFFF, GAIN_ONE);
    send_item(24'h123456, 24'd262144, 17'd32768);
    send_item(24'hEDCBA9, 24'd262145, 17'd32768);
    // Alternating bit patterns in every field, and the smallest gain.
    send_item(24'h555555, 24'hAAAAAA, 17'h15555);
    send_item(24'hAAAAAA, 24'h555555, 17'h0AAAA);
    send_item(24'h000000, 24'd128, 17'd1);
    send_item(SAMPLE_MIN, 24'd1, GAIN_ONE);
    send_item(SAMPLE_MAX, 24'd767, 17'd65535);
    wait_drained();

    // Random items under a sweep of maximum-delay settings. The sweep takes
    // in zero (acts as one), the smallest and largest legal values and the
    // value one above the largest legal one.
    for (int p = 0; p < SETTING_COUNT; p++) begin
      write_max(max_sweep[p]);
      lim  = (max_sweep[p] == 0) ? 1 :
             ((max_sweep[p] > DEPTH - 2) ? DEPTH - 2 : max_sweep[p]);
      calm = (p == 4);
      for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
        // Mid-way through one setting the result side holds off for a long
        // stretch, and later the sender pauses until everything is back.
        if (p == 5 && k == 40) sink_hold = 1'b1;
        if (p == 5 && k == 90) wait_drained();
        send_random(lim);
      end
      wait_drained();
    end
    calm = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    tracker.close_out();

    $display("Ran %0d items under the reset maximum and %0d register settings;",
             items_sent, SETTING_COUNT);
    $display("%0d results compared, %0d of them saturated, %0d mismatches.",
             tracker.checked, tracker.clipped, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("tb_interpolated_feedback_delay_line_top passed");
    end else begin
      $display("tb_interpolated_feedback_delay_line_top failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
